@@ rtl/core/byte_entropy_classifier_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Byte entropy classifier assertion macros
// Shared property templates for the port checker.
// ---------------------------------------------------------------------------
`ifndef BYTE_ENTROPY_CLASSIFIER_UNIT_DEFINES_SVH
`define BYTE_ENTROPY_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BEC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("bec assertion failed");

// next-cycle implication
`define BEC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("bec assertion failed");

`endif

@@ rtl/core/bec_pkg.sv @@
// ---------------------------------------------------------------------------
// Byte entropy classifier package
// Beat types, widths and classification constants.
// ---------------------------------------------------------------------------
`default_nettype none

package bec_pkg;

  localparam int BINS            = 256;
  localparam int BIN_W           = $clog2(BINS);
  localparam int LOG2_MAX_REGION = 32;
  localparam int FRAC_BITS       = 16;
  localparam int FI_W            = $clog2(FRAC_BITS);
  localparam int CNT_W           = LOG2_MAX_REGION + 1;
  localparam int INT_W           = $clog2(CNT_W);
  localparam int LOG_W           = INT_W + FRAC_BITS;
  localparam int MANT_W          = 32;
  localparam int SUM_W           = CNT_W + LOG_W + 1;
  localparam int DIVN_W          = $clog2(SUM_W);
  localparam int MUL_W           = (CNT_W > MANT_W) ? CNT_W : MANT_W;
  localparam int ENT_W           = 20;
  localparam int SCORE_W         = 16;
  localparam int FLAGS_W         = 8;
  localparam int ADDR_W          = 4;

  localparam logic [ENT_W-1:0]   ENT_MAX   = '1;
  localparam logic [31:0]        EXEC_BIT  = 32'h2000_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [1:0] REG_SUSP_LOW  = 2'd0;
  localparam logic [1:0] REG_SUSP_HIGH = 2'd1;
  localparam logic [1:0] REG_MAL_LEVEL = 2'd2;

  localparam logic [ENT_W-1:0] RST_SUSP_LOW  = 20'd471859;
  localparam logic [ENT_W-1:0] RST_SUSP_HIGH = 20'd498074;
  localparam logic [ENT_W-1:0] RST_MAL_LEVEL = 20'd524288;

  localparam logic [1:0] STAT_CLEAN = 2'd0;
  localparam logic [1:0] STAT_SUSP  = 2'd1;
  localparam logic [1:0] STAT_HIGH  = 2'd2;
  localparam logic [1:0] STAT_MAL   = 2'd3;

  localparam logic [SCORE_W-1:0] HP_SUSP = 16'd3;
  localparam logic [SCORE_W-1:0] HP_HIGH = 16'd6;
  localparam logic [SCORE_W-1:0] HP_MAL  = 16'd12;
  localparam logic [SCORE_W-1:0] HP_EXEC = 16'd6;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] section_index;
    logic [31:0] characteristics;
  } bec_in_t;

  typedef struct packed {
    logic [ENT_W-1:0]   entropy_value;
    logic [1:0]         status;
    logic               exec_flagged;
    logic [SCORE_W-1:0] score_half_points;
    logic [FLAGS_W-1:0] flag_count;
  } bec_out_t;

endpackage

`default_nettype wire

@@ rtl/core/bec_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/byte_entropy_classifier_unit.sv @@
// ---------------------------------------------------------------------------
// Byte entropy classifier
// Byte histogram, Shannon entropy over a shared multiplier, classification.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  in      | input     | in_valid / stall   | bec_in_t
//  out     | output    | out_valid / stall  | bec_out_t
//  cfg     | input     | APB write/read     | 20-bit thresholds
//
//  Data byte: histogram read, then write back.
//  Section check: straight to the finish step, which waits for a free output register.
//  Region end: each bin is read; each nonzero bin is normalized, squared once per
//  fraction bit, and its count multiplied by its log2; then a restoring divide by
//  the length and one more log2 of the length. The single multiplier serializes the products.
//  Reset clears the histogram valid bits at once; no clearing pass.
//  A result waiting under out_stall holds the sequencer only at its last step.
`default_nettype none

module byte_entropy_classifier_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire bec_pkg::bec_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bec_pkg::bec_out_t       out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [bec_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import bec_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT, ST_SW_RD, ST_SW_DAT, ST_LG_NORM, ST_LG_MUL, ST_LG_FIX,
    ST_ACC_MUL, ST_ACC_ADD, ST_DIV, ST_FIN_E, ST_FINISH
  } state_e;

  state_e             state_q;
  logic [ENT_W-1:0]   low_q, high_q, mal_q;
  logic [BINS-1:0]    vld_q;
  logic [CNT_W-1:0]   len_q, cnt_q, lg_mm_q;
  logic [INT_W-1:0]   lg_p_q;
  logic [MANT_W-1:0]  m_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [FI_W-1:0]    fi_q;
  logic               lg_len_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   rem_q;
  logic [DIVN_W-1:0]  divn_q;
  logic [BIN_W-1:0]   idx_q, byte_q, rd_addr_q;
  logic               last_q, region_q, flag_q;
  logic [ENT_W-1:0]   e_q;
  logic [2*MUL_W-1:0] prod_q;
  logic [SCORE_W-1:0] score_q;
  logic [FLAGS_W-1:0] flags_q;
  bec_out_t           out_q;
  logic               out_vld_q;

  // histogram ram
  logic               ram_we, ram_re;
  logic [BIN_W-1:0]   ram_raddr;
  logic [CNT_W-1:0]   ram_rdata, rd_cnt;

  bec_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_q),
    .wdata_i (rd_cnt + CNT_W'(1)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_acc;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign rd_cnt      = vld_q[rd_addr_q] ? ram_rdata : '0;
  assign ram_we      = (state_q == ST_CNT) && !len_q[CNT_W-1];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    if (state_q == ST_IDLE) begin
      ram_re    = in_acc && (in_data_i.action == ACT_BYTE);
      ram_raddr = in_data_i.data_byte;
    end else if (state_q == ST_SW_RD) begin
      ram_re = 1'b1;
    end
  end

  // configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_SUSP_LOW:  prdata = 32'(low_q);
      REG_SUSP_HIGH: prdata = 32'(high_q);
      REG_MAL_LEVEL: prdata = 32'(mal_q);
      default:       prdata = '0;
    endcase
  end

  // shared multiplier
  logic [MUL_W-1:0] mul_a, mul_b;
  always_comb begin
    if (state_q == ST_ACC_MUL) begin
      mul_a = MUL_W'(cnt_q);
      mul_b = MUL_W'({lg_p_q, frac_q});
    end else begin
      mul_a = MUL_W'(m_q);
      mul_b = MUL_W'(m_q);
    end
  end

  // divider step
  logic [CNT_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_q, sum_q[SUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, len_q};

  // final entropy and classification
  logic [LOG_W-1:0]   ln;
  logic [LOG_W-1:0]   ln_diff;
  logic [ENT_W-1:0]   e_val;
  assign ln      = {lg_p_q, frac_q};
  assign ln_diff = ln - sum_q[LOG_W-1:0];
  always_comb begin
    if (sum_q > SUM_W'(ln)) begin
      e_val = '0;
    end else if (ln_diff > LOG_W'(ENT_MAX)) begin
      e_val = ENT_MAX;
    end else begin
      e_val = ln_diff[ENT_W-1:0];
    end
  end

  logic [1:0]         stat;
  logic [SCORE_W-1:0] hp;
  logic               raise;
  logic [SCORE_W:0]   score_sum;
  always_comb begin
    stat  = STAT_CLEAN;
    hp    = '0;
    raise = 1'b0;
    if (region_q) begin
      if (e_q > low_q && e_q < high_q) begin
        stat = STAT_SUSP;  hp = HP_SUSP; raise = 1'b1;
      end else if (e_q > high_q && e_q < mal_q) begin
        stat = STAT_HIGH;  hp = HP_HIGH; raise = 1'b1;
      end else if (e_q >= mal_q) begin
        stat = STAT_MAL;   hp = HP_MAL;  raise = 1'b1;
      end
    end else if (flag_q) begin
      hp = HP_EXEC; raise = 1'b1;
    end
  end
  assign score_sum = {1'b0, score_q} + {1'b0, hp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      low_q     <= RST_SUSP_LOW;
      high_q    <= RST_SUSP_HIGH;
      mal_q     <= RST_MAL_LEVEL;
      vld_q     <= '0;
      len_q     <= '0;
      score_q   <= '0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (paddr[ADDR_W-1:2])
          REG_SUSP_LOW:  low_q  <= pwdata[ENT_W-1:0];
          REG_SUSP_HIGH: high_q <= pwdata[ENT_W-1:0];
          REG_MAL_LEVEL: mal_q  <= pwdata[ENT_W-1:0];
          default: ;
        endcase
      end
      // the finish step refills the output register itself
      if (out_vld_q && !out_stall_i && state_q != ST_FINISH) begin
        out_vld_q <= 1'b0;
      end
      if (ram_re) begin
        rd_addr_q <= ram_raddr;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            byte_q   <= in_data_i.data_byte;
            last_q   <= in_data_i.last;
            region_q <= (in_data_i.action == ACT_BYTE);
            flag_q   <= (in_data_i.section_index != '0) &&
                        ((in_data_i.characteristics & EXEC_BIT) != '0);
            e_q      <= '0;
            state_q  <= (in_data_i.action == ACT_BYTE) ? ST_CNT : ST_FINISH;
          end
        end
        ST_CNT: begin
          if (!len_q[CNT_W-1]) begin
            vld_q[byte_q] <= 1'b1;
            len_q         <= len_q + CNT_W'(1);
          end
          idx_q   <= '0;
          sum_q   <= '0;
          state_q <= last_q ? ST_SW_RD : ST_IDLE;
        end
        ST_SW_RD: state_q <= ST_SW_DAT;
        ST_SW_DAT: begin
          if (rd_cnt != '0) begin
            cnt_q    <= rd_cnt;
            lg_mm_q  <= rd_cnt;
            lg_p_q   <= INT_W'(CNT_W - 1);
            lg_len_q <= 1'b0;
            state_q  <= ST_LG_NORM;
          end else if (&idx_q) begin
            rem_q   <= '0;
            divn_q  <= DIVN_W'(SUM_W - 1);
            state_q <= ST_DIV;
          end else begin
            idx_q   <= idx_q + BIN_W'(1);
            state_q <= ST_SW_RD;
          end
        end
        ST_LG_NORM: begin
          if (lg_mm_q[CNT_W-1]) begin
            m_q     <= lg_mm_q[CNT_W-1 -: MANT_W];
            frac_q  <= '0;
            fi_q    <= '0;
            state_q <= ST_LG_MUL;
          end else begin
            lg_mm_q <= lg_mm_q << 1;
            lg_p_q  <= lg_p_q - INT_W'(1);
          end
        end
        ST_LG_MUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= ST_LG_FIX;
        end
        ST_LG_FIX: begin
          // square >> 31; a carry into bit 32 gives a one and renormalizes
          if (prod_q[2*MANT_W-1]) begin
            m_q    <= prod_q[2*MANT_W-1 -: MANT_W];
            frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
          end else begin
            m_q    <= prod_q[2*MANT_W-2 -: MANT_W];
            frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
          end
          fi_q <= fi_q + FI_W'(1);
          if (fi_q == FI_W'(FRAC_BITS - 1)) begin
            state_q <= lg_len_q ? ST_FIN_E : ST_ACC_MUL;
          end else begin
            state_q <= ST_LG_MUL;
          end
        end
        ST_ACC_MUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= ST_ACC_ADD;
        end
        ST_ACC_ADD: begin
          sum_q <= sum_q + prod_q[SUM_W-1:0];
          if (&idx_q) begin
            rem_q   <= '0;
            divn_q  <= DIVN_W'(SUM_W - 1);
            state_q <= ST_DIV;
          end else begin
            idx_q   <= idx_q + BIN_W'(1);
            state_q <= ST_SW_RD;
          end
        end
        ST_DIV: begin
          // restoring division, quotient shifts into sum_q
          rem_q  <= q_bit ? CNT_W'(rem_sh - {1'b0, len_q}) : rem_sh[CNT_W-1:0];
          sum_q  <= {sum_q[SUM_W-2:0], q_bit};
          divn_q <= divn_q - DIVN_W'(1);
          if (divn_q == '0) begin
            lg_mm_q  <= len_q;
            lg_p_q   <= INT_W'(CNT_W - 1);
            lg_len_q <= 1'b1;
            state_q  <= ST_LG_NORM;
          end
        end
        ST_FIN_E: begin
          e_q     <= e_val;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q               <= 1'b1;
            out_q.entropy_value     <= e_q;
            out_q.status            <= stat;
            out_q.exec_flagged      <= !region_q && flag_q;
            out_q.score_half_points <= score_sum[SCORE_W] ? SCORE_MAX
                                                          : score_sum[SCORE_W-1:0];
            out_q.flag_count        <= flags_q + FLAGS_W'(raise);
            score_q                 <= score_sum[SCORE_W] ? SCORE_MAX
                                                          : score_sum[SCORE_W-1:0];
            flags_q                 <= flags_q + FLAGS_W'(raise);
            if (region_q) begin
              vld_q <= '0;
              len_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bec_checker.sv @@
// ---------------------------------------------------------------------------
// Byte entropy classifier checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "byte_entropy_classifier_unit_defines.svh"

module bec_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire bec_pkg::bec_in_t   in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire bec_pkg::bec_out_t  out_data_o
);
  import bec_pkg::*;

  logic stall_beat, exec_beat, flag_beat;
  assign stall_beat = out_valid_o && out_stall_i;
  assign exec_beat  = out_valid_o && out_data_o.exec_flagged;
  assign flag_beat  = out_valid_o && (out_data_o.status != STAT_CLEAN);

  `BEC_ASSERT_NXT(a_out_hold, stall_beat, out_valid_o && $stable(out_data_o))
  `BEC_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `BEC_ASSERT_IMP(a_exec_clean, exec_beat, out_data_o.status == STAT_CLEAN)
  `BEC_ASSERT_IMP(a_exec_no_entropy, exec_beat, out_data_o.entropy_value == '0)
  `BEC_ASSERT_IMP(a_status_no_exec, flag_beat, !out_data_o.exec_flagged)

endmodule

bind byte_entropy_classifier_unit bec_checker u_bec_checker (.*);

`default_nettype wire
